### rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define RMSPU_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("rmspu assertion failed");

// Checked on every rising clock edge, reset included.
`define RMSPU_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("rmspu assertion failed");

`endif

### rtl/core/rmspu_pkg.sv
// Types and constants shared by the RMSProp update pipeline.
`timescale 1ns / 1ps
package rmspu_pkg;

	localparam int IDX_W   = 12;
	localparam int CACHE_W = 48;
	localparam int X_W     = 49;
	localparam int PD_W    = 54;
	localparam int ROOT_W  = 32;
	localparam int Q_W     = 35;

	localparam logic [1:0] REG_RHO = 2'd0;
	localparam logic [1:0] REG_LR  = 2'd1;
	localparam logic [1:0] REG_EPS = 2'd2;

	localparam logic [Q_W-1:0] STEP_CAP = 35'h4_0000_0000;

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic               neg;
		logic signed [31:0] p;
		logic               sat_c;
		logic               prod_zero;
		logic [PD_W-1:0]    pd;
	} side_t;

endpackage

### rtl/core/rmspu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rmspu_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/rmspu_front.sv
// Front stages: gradient products, cache read-modify-write with forwarding, clearing pass.
`timescale 1ns / 1ps
module rmspu_front #(
	parameter int PARAM_COUNT = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_take,
	input  logic [11:0]         param_index,
	input  logic signed [31:0]  gradient,
	input  logic signed [31:0]  param_value,
	input  logic [15:0]         rho,
	input  logic [31:0]         step_rate,
	input  logic [31:0]         epsilon,
	output logic                clearing,
	output logic                v_out,
	output rmspu_pkg::side_t    side_out,
	output logic [48:0]         x_out
);
	import rmspu_pkg::*;

	localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
	localparam logic [AW-1:0] LAST = AW'(PARAM_COUNT - 1);

	logic          clear_q;
	logic [AW-1:0] clr_addr_q;

	logic [31:0] g_u;
	logic [31:0] mag_d;

	logic               v_s1, neg_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [31:0]        mag_s1;
	logic signed [31:0] p_s1;

	logic               v_s2, neg_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic signed [31:0] p_s2;
	logic [CACHE_W-1:0] g2_s2;
	logic [63:0]        prod_s2;

	logic               v_s3, neg_s3, inr_s3, pz_s3;
	logic [IDX_W-1:0]   idx_s3;
	logic signed [31:0] p_s3;
	logic [64:0]        b_s3;
	logic [PD_W-1:0]    pd_s3;

	logic               v_s4, neg_s4, inr_s4, pz_s4, sat_s4;
	logic [IDX_W-1:0]   idx_s4;
	logic signed [31:0] p_s4;
	logic [CACHE_W-1:0] nc_s4;
	logic [PD_W-1:0]    pd_s4;

	logic [63:0]        sq_d;
	logic [63:0]        prod_d;
	logic [16:0]        rho_c;
	logic [64:0]        b_d;
	logic               inr_d;
	logic [CACHE_W-1:0] rd_data;
	logic               fwd;
	logic [CACHE_W-1:0] c_d;
	logic [63:0]        a_d;
	logic [64:0]        sum_d;
	logic [48:0]        nc_wide;
	logic [CACHE_W-1:0] nc_d;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [CACHE_W-1:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST) begin
				clear_q <= 1'b0;
			end
		end
	end

	assign clearing = clear_q;

	assign g_u   = gradient;
	assign mag_d = g_u[31] ? (32'd0 - g_u) : g_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign sq_d   = 64'(mag_s1) * 64'(mag_s1);
	assign prod_d = 64'(step_rate) * 64'(mag_s1);
	assign rho_c  = 17'h10000 - {1'b0, rho};
	assign b_d    = 65'(rho_c) * 65'(g2_s2);
	assign inr_d  = 32'(idx_s2) < 32'(PARAM_COUNT);

	assign fwd     = v_s4 && inr_s4 && (idx_s4 == idx_s3);
	assign c_d     = fwd ? nc_s4 : (inr_s3 ? rd_data : '0);
	assign a_d     = 64'(rho) * 64'(c_d);
	assign sum_d   = 65'(a_d) + b_s3;
	assign nc_wide = sum_d[64:16];
	assign nc_d    = nc_wide[48] ? {CACHE_W{1'b1}} : nc_wide[47:0];

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= param_index;
			mag_s1  <= mag_d;
			neg_s1  <= g_u[31];
			p_s1    <= param_value;

			idx_s2  <= idx_s1;
			neg_s2  <= neg_s1;
			p_s2    <= p_s1;
			g2_s2   <= sq_d[63:16];
			prod_s2 <= prod_d;

			idx_s3  <= idx_s2;
			neg_s3  <= neg_s2;
			p_s3    <= p_s2;
			inr_s3  <= inr_d;
			b_s3    <= b_d;
			pd_s3   <= prod_s2[62:9];
			pz_s3   <= (prod_s2 == 64'd0);

			idx_s4  <= idx_s3;
			neg_s4  <= neg_s3;
			p_s4    <= p_s3;
			inr_s4  <= inr_s3;
			nc_s4   <= nc_d;
			sat_s4  <= nc_wide[48];
			pd_s4   <= pd_s3;
			pz_s4   <= pz_s3;
		end
	end

	assign we    = clear_q || (en && v_s3 && inr_s3);
	assign waddr = clear_q ? clr_addr_q : AW'(idx_s3);
	assign wdata = clear_q ? '0 : nc_d;

	rmspu_ram #(
		.WIDTH(CACHE_W),
		.DEPTH(PARAM_COUNT),
		.AW   (AW)
	) u_cache (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (en),
		.raddr(AW'(idx_s2)),
		.rdata(rd_data)
	);

	assign v_out              = v_s4;
	assign side_out.idx       = idx_s4;
	assign side_out.neg       = neg_s4;
	assign side_out.p         = p_s4;
	assign side_out.sat_c     = sat_s4;
	assign side_out.prod_zero = pz_s4;
	assign side_out.pd        = pd_s4;
	assign x_out              = {1'b0, nc_s4} + 49'(epsilon);

endmodule

### rtl/core/rmspu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module rmspu_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  rmspu_pkg::side_t side_in,
	input  logic [48:0]      x_in,
	output logic             v_out,
	output rmspu_pkg::side_t side_out,
	output logic [31:0]      root_out
);
	import rmspu_pkg::*;

	localparam int N = ROOT_W;

	logic        v_s    [1:N];
	side_t       side_s [1:N];
	logic [33:0] rem_s  [1:N];
	logic [31:0] root_s [1:N];
	logic [63:0] rad_s  [1:N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic        v_c;
		side_t       side_c;
		logic [33:0] rem_c;
		logic [31:0] root_c;
		logic [63:0] rad_c;
		logic [35:0] r2;
		logic [35:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign v_c    = v_in;
			assign side_c = side_in;
			assign rem_c  = '0;
			assign root_c = '0;
			assign rad_c  = {1'b0, x_in, 14'd0};
		end else begin : g_next
			assign v_c    = v_s[k];
			assign side_c = side_s[k];
			assign rem_c  = rem_s[k];
			assign root_c = root_s[k];
			assign rad_c  = rad_s[k];
		end

		assign r2    = {rem_c, rad_c[63:62]};
		assign trial = {2'b00, root_c, 2'b01};
		assign ge    = r2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_c;
				rem_s[k+1]  <= ge ? 34'(r2 - trial) : r2[33:0];
				root_s[k+1] <= {root_c[30:0], ge};
				rad_s[k+1]  <= {rad_c[61:0], 2'b00};
			end
		end
	end

	assign v_out    = v_s[N];
	assign side_out = side_s[N];
	assign root_out = root_s[N];

endmodule

### rtl/core/rmspu_div.sv
// Pipelined restoring divider for the step size, one quotient bit per stage.
`timescale 1ns / 1ps
module rmspu_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  rmspu_pkg::side_t side_in,
	input  logic [31:0]      root_in,
	output logic             v_out,
	output rmspu_pkg::side_t side_out,
	output logic [34:0]      quot_out,
	output logic             cap_out
);
	import rmspu_pkg::*;

	localparam int N = Q_W;

	logic        ovf;
	logic        v_s    [1:N];
	side_t       side_s [1:N];
	logic [31:0] rem_s  [1:N];
	logic [Q_W-1:0] quot_s [1:N];
	logic [Q_W-1:0] lo_s   [1:N];
	logic [31:0] dvs_s  [1:N];
	logic        cap_s  [1:N];

	assign ovf = {13'd0, side_in.pd[PD_W-1:Q_W]} >= root_in;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic           v_c;
		side_t          side_c;
		logic [31:0]    rem_c;
		logic [Q_W-1:0] quot_c;
		logic [Q_W-1:0] lo_c;
		logic [31:0]    dvs_c;
		logic           cap_c;
		logic [32:0]    r2;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_c    = v_in;
			assign side_c = side_in;
			assign rem_c  = {13'd0, side_in.pd[PD_W-1:Q_W]};
			assign quot_c = '0;
			assign lo_c   = side_in.pd[Q_W-1:0];
			assign dvs_c  = root_in;
			assign cap_c  = !side_in.prod_zero && ovf;
		end else begin : g_next
			assign v_c    = v_s[k];
			assign side_c = side_s[k];
			assign rem_c  = rem_s[k];
			assign quot_c = quot_s[k];
			assign lo_c   = lo_s[k];
			assign dvs_c  = dvs_s[k];
			assign cap_c  = cap_s[k];
		end

		assign r2 = {rem_c, lo_c[Q_W-1]};
		assign ge = r2 >= {1'b0, dvs_c};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_c;
				rem_s[k+1]  <= ge ? 32'(r2 - {1'b0, dvs_c}) : r2[31:0];
				quot_s[k+1] <= {quot_c[Q_W-2:0], ge};
				lo_s[k+1]   <= {lo_c[Q_W-2:0], 1'b0};
				dvs_s[k+1]  <= dvs_c;
				cap_s[k+1]  <= cap_c;
			end
		end
	end

	assign v_out    = v_s[N];
	assign side_out = side_s[N];
	assign quot_out = quot_s[N];
	assign cap_out  = cap_s[N];

endmodule

### rtl/core/rmsprop_parameter_update_unit.sv
// Top level of the RMSProp parameter update pipeline.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    param_index, gradient, param_value
//   out       output     out_valid / out_stall  out_index, new_value, saturated
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low; its result shows after it has passed
// 72 registers: four front stages, 32 square root stages, 35 divider stages
// and the output register.
// After reset a clearing pass zeroes every cache entry, with in_stall high throughout.
// While a result waits under out_stall, the whole pipeline holds and in_stall is high.
// Configuration writes are taken in any cycle, cfg_ready is always high.
`timescale 1ns / 1ps
module rmsprop_parameter_update_unit #(
	parameter int PARAM_COUNT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [11:0]        param_index,
	input  logic signed [31:0] gradient,
	input  logic signed [31:0] param_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        out_index,
	output logic signed [31:0] new_value,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import rmspu_pkg::*;

	logic [15:0] rho_q;
	logic [31:0] lr_q;
	logic [31:0] eps_q;

	logic en, clearing, in_take;

	logic        v_f, v_r, v_d;
	side_t       side_f, side_r, side_d;
	logic [48:0] x_f;
	logic [31:0] root_r;
	logic [Q_W-1:0] quot_d;
	logic        cap_d;

	logic [Q_W-1:0]     q_d;
	logic signed [36:0] p_ext, q_ext, nv_d;
	logic               hi_d, lo_d;
	logic signed [31:0] nv_sat;

	logic               out_valid_q;
	logic [11:0]        out_index_q;
	logic signed [31:0] new_value_q;
	logic               saturated_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rho_q <= 16'd58982;
			lr_q  <= 32'd4294967;
			eps_q <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RHO: rho_q <= cfg_data[15:0];
				REG_LR:  lr_q  <= cfg_data;
				REG_EPS: eps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en || clearing;
	assign in_take  = in_valid && !in_stall;

	rmspu_front #(
		.PARAM_COUNT(PARAM_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_take      (in_take),
		.param_index  (param_index),
		.gradient     (gradient),
		.param_value  (param_value),
		.rho          (rho_q),
		.step_rate    (lr_q),
		.epsilon      (eps_q),
		.clearing     (clearing),
		.v_out        (v_f),
		.side_out     (side_f),
		.x_out        (x_f)
	);

	rmspu_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_f),
		.side_in (side_f),
		.x_in    (x_f),
		.v_out   (v_r),
		.side_out(side_r),
		.root_out(root_r)
	);

	rmspu_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_r),
		.side_in (side_r),
		.root_in (root_r),
		.v_out   (v_d),
		.side_out(side_d),
		.quot_out(quot_d),
		.cap_out (cap_d)
	);

	assign q_d    = side_d.prod_zero ? '0
		: ((cap_d || (quot_d > STEP_CAP)) ? STEP_CAP : quot_d);
	assign p_ext  = 37'(side_d.p);
	assign q_ext  = $signed({2'b00, q_d});
	assign nv_d   = side_d.neg ? (p_ext + q_ext) : (p_ext - q_ext);
	assign hi_d   = nv_d > 37'sd2147483647;
	assign lo_d   = nv_d < -37'sd2147483648;
	assign nv_sat = hi_d ? 32'sh7FFFFFFF : (lo_d ? 32'sh80000000 : nv_d[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_index_q <= side_d.idx;
			new_value_q <= nv_sat;
			saturated_q <= side_d.sat_c || hi_d || lo_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign new_value = new_value_q;
	assign saturated = saturated_q;

endmodule

### rtl/core/rmspu_checker.sv
// Port-level checker for the RMSProp update unit, with its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmspu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [11:0]        out_index,
	input logic signed [31:0] new_value,
	input logic               saturated
);

	`RMSPU_ASSERT_ALWAYS(a_stall_in_reset, clk, !arst_n |-> in_stall)
	`RMSPU_ASSERT(a_back_pressure, clk, arst_n, (out_valid && out_stall) |-> in_stall)
	`RMSPU_ASSERT(a_out_hold, clk, arst_n,
		(out_valid && out_stall) |=> (out_valid && $stable(new_value)
		&& $stable(out_index) && $stable(saturated)))
	`RMSPU_ASSERT(a_sat_rail, clk, arst_n,
		(out_valid && saturated) |-> (new_value == 32'sh7FFFFFFF || new_value == 32'sh80000000))

endmodule

bind rmsprop_parameter_update_unit rmspu_checker u_rmspu_checker (.*);

### tb/rmsprop_parameter_update_unit_tb.sv
// Self-checking testbench for the RMSProp parameter update unit with a cycle-free predictor.
`timescale 1ns / 1ps
module rmsprop_parameter_update_unit_tb;
	import rmspu_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam longint unsigned CACHE_LIMIT = (64'd1 << 48) - 64'd1;
	localparam longint unsigned MAX_STEP = 64'd1 << 34;
	localparam int DRAIN_CYCLES = 90;

	typedef struct {
		logic [11:0]        idx;
		logic signed [31:0] value;
		logic               sat;
	} update_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b1;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [11:0]        param_index = '0;
	logic signed [31:0] gradient = '0;
	logic signed [31:0] param_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [11:0]        out_index;
	logic signed [31:0] new_value;
	logic               saturated;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	longint unsigned rho_reg;
	longint unsigned lr_reg;
	longint unsigned eps_reg;
	logic [47:0] sq_cache [4096];
	update_t pending_updates [$];
	int errors = 0;
	int items_sent = 0;
	int updates_checked = 0;
	int sat_seen = 0;
	bit calm = 1'b0;

	rmsprop_parameter_update_unit i_dut (.*);

	always #2 clk = ~clk;

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic update_t apply_update(logic [11:0] idx, logic signed [31:0] g,
			logic signed [31:0] p);
		update_t u;
		longint unsigned mag, g2, a, b, nc, x, s, prod, q;
		longint signed gs, nv;
		bit neg;
		u.sat = 1'b0;
		gs = g;
		neg = g[31];
		mag = neg ? -gs : gs;
		g2 = (mag * mag) >> 16;
		a = rho_reg * sq_cache[idx];
		b = (64'd65536 - rho_reg) * g2;
		nc = (a >> 16) + (b >> 16) + (((a & 64'hFFFF) + (b & 64'hFFFF)) >> 16);
		if (nc > CACHE_LIMIT) begin
			nc = CACHE_LIMIT;
			u.sat = 1'b1;
		end
		sq_cache[idx] = nc[47:0];
		x = nc + eps_reg;
		s = floor_root(x << 14);
		prod = lr_reg * mag;
		if (prod == 0)
			q = 0;
		else if (s == 0)
			q = MAX_STEP;
		else begin
			q = prod / (s << 9);
			if (q > MAX_STEP)
				q = MAX_STEP;
		end
		nv = neg ? longint'(p) + longint'(q) : longint'(p) - longint'(q);
		if (nv > 64'sh7FFFFFFF) begin
			nv = 64'sh7FFFFFFF;
			u.sat = 1'b1;
		end else if (nv < -64'sh80000000) begin
			nv = -64'sh80000000;
			u.sat = 1'b1;
		end
		u.idx = idx;
		u.value = nv[31:0];
		return u;
	endfunction

	// An item is sent at a rising edge; the caller returns right after acceptance.
	task automatic send_item(logic [11:0] idx, logic signed [31:0] g, logic signed [31:0] p);
		if (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 8);
		end
		in_valid <= 1'b1;
		param_index <= idx;
		gradient <= g;
		param_value <= p;
		do @(posedge clk); while (in_stall);
		pending_updates.push_back(apply_update(idx, g, p));
		items_sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_updates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [31:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			REG_RHO: rho_reg = data[15:0];
			REG_LR: lr_reg = data;
			REG_EPS: eps_reg = data;
			default: ;
		endcase
	endtask

	function automatic logic signed [31:0] random_gradient();
		int pick;
		logic [31:0] v;
		pick = $urandom_range(9);
		v = $urandom;
		if (pick < 4)
			return v;
		if (pick < 7)
			return $urandom_range(1) ? -(v >> $urandom_range(31, 8)) : (v >> $urandom_range(31, 8));
		if (pick < 8)
			return $urandom_range(1) ? 32'sh7FFFFFFF : -32'sh80000000;
		return $urandom_range(1) ? -(v >> 24) : (v >> 24);
	endfunction

	function automatic logic signed [31:0] random_param();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? 32'sh7FFFFFFF - $urandom_range(255)
				: -32'sh80000000 + $urandom_range(255);
		return $urandom;
	endfunction

	task automatic random_items(int count);
		logic [11:0] idx;
		for (int k = 0; k < count; k++) begin
			idx = ($urandom_range(9) < 6) ? 12'($urandom_range(15)) : 12'($urandom);
			send_item(idx, random_gradient(), random_param());
		end
	endtask

	task automatic test_field_extremes;
		send_item(12'd0, 32'sd0, 32'sd0);
		send_item(12'd4095, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_item(12'd4095, -32'sh80000000, -32'sh80000000);
		send_item(12'd1, -32'sd1, 32'sh7FFFFFFF);
		send_item(12'd2, 32'sd1, -32'sh80000000);
		send_item(12'd3, 32'sh01000000, 32'sh00000000);
		send_item(12'd3, -32'sh01000000, 32'shFFFFFFFF);
		send_item(12'd2730, 32'sh55555555, 32'shAAAAAAAA);
		send_item(12'd1365, 32'shAAAAAAAA, 32'sh55555555);
	endtask

	task automatic test_register_extremes;
		write_reg(REG_RHO, 32'h0000FFFF);
		send_item(12'd1, 32'sh00800000, 32'sd12345);
		write_reg(REG_RHO, 32'd0);
		send_item(12'd1, 32'sh00800000, 32'sd12345);
		write_reg(REG_LR, 32'hFFFFFFFF);
		send_item(12'd5, 32'sh7FFFFFFF, -32'sh7F000000);
		write_reg(REG_LR, 32'd0);
		send_item(12'd5, -32'sh40000000, 32'sd77);
		write_reg(REG_UNUSED, 32'hFFFFFFFF);
		send_item(12'd6, 32'sh00100000, 32'sd0);
	endtask

	// With no epsilon and a cache that stays zero, the root is zero.
	task automatic test_zero_root;
		write_reg(REG_RHO, 32'd58982);
		write_reg(REG_LR, 32'h80000000);
		write_reg(REG_EPS, 32'd0);
		send_item(12'd100, 32'sd0, 32'sd999);
		send_item(12'd101, 32'sd200, 32'sd5);
		send_item(12'd102, -32'sd200, -32'sd5);
		write_reg(REG_LR, 32'd0);
		send_item(12'd103, 32'sd100, 32'sd5);
		write_reg(REG_EPS, 32'hFFFFFFFF);
		send_item(12'd104, 32'sd100, 32'sd5);
	endtask

	task automatic test_random_settings;
		write_reg(REG_RHO, 32'd58982);
		write_reg(REG_LR, 32'd4294967);
		write_reg(REG_EPS, 32'd1);
		random_items(200);
		write_reg(REG_RHO, 32'd0);
		write_reg(REG_LR, 32'hFFFFFFFF);
		random_items(150);
		write_reg(REG_RHO, 32'h0000FFFF);
		write_reg(REG_EPS, 32'd0);
		random_items(150);
		write_reg(REG_RHO, $urandom);
		write_reg(REG_LR, $urandom);
		write_reg(REG_EPS, $urandom);
		random_items(150);
		drain();
		random_items(150);
		write_reg(REG_LR, $urandom >> $urandom_range(31));
		write_reg(REG_EPS, $urandom >> $urandom_range(31));
		random_items(100);
	endtask

	task automatic test_back_to_back;
		calm = 1'b1;
		random_items(150);
		calm = 1'b0;
	endtask

	always @(posedge clk)
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 8);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_updates.size() == 0) begin
				$error("unexpected item: out_index %0d", out_index);
				errors++;
			end else begin
				update_t u;
				u = pending_updates.pop_front();
				if (out_index !== u.idx) begin
					$error("out_index expected %0d actual %0d", u.idx, out_index);
					errors++;
				end
				if (new_value !== u.value) begin
					$error("new_value expected %0d actual %0d", u.value, new_value);
					errors++;
				end
				if (saturated !== u.sat) begin
					$error("saturated expected %0d actual %0d", u.sat, saturated);
					errors++;
				end
				updates_checked++;
				sat_seen += u.sat;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		rho_reg = 58982;
		lr_reg = 4294967;
		eps_reg = 1;
		foreach (sq_cache[i])
			sq_cache[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_register_extremes();
		test_zero_root();
		test_random_settings();
		test_back_to_back();
		drain();
		if (pending_updates.size() != 0) begin
			$error("%0d expected items never arrived", pending_updates.size());
			errors++;
		end
		$display("Sent %0d items over several register settings; checked %0d results, %0d saturated.",
			items_sent, updates_checked, sat_seen);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#4ms;
		$display("Timed out with %0d items still expected.", pending_updates.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
